// ----- src/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define CHK_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// same, on the usual clk and rst_n names
`define CHK_ASSERT_DEF(lbl, prop, msg) \
    `CHK_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

// ----- src/csvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types and constants shared by the csv field splitter modules.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 1'd1;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    localparam logic [1:0] FIELD_SURPLUS = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] field_number;
        logic       field_end;
        logic       record_end;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- src/csvfs_front.sv -----
// ----------------------------------------------------------------------------
// csvfs_front
// Classifies each character, tracks quote and field state, and writes the
// resulting item into the queue.
// ----------------------------------------------------------------------------
module csvfs_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [csvfs_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                               accept,
    input  logic [7:0]                         char_byte,
    input  logic                               line_end,
    output logic                               q_wr,
    output csvfs_pkg::res_t                    q_data
);
    import csvfs_pkg::*;

    logic [7:0] sep_reg;
    logic [7:0] quote_reg;
    logic       inq_reg,   inq_next;
    logic       acq_reg,   acq_next;
    logic [1:0] cnt_reg,   cnt_next;
    logic       emit;
    logic       is_quote;
    logic       is_sep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= SEPARATOR_RESET;
            quote_reg <= QUOTE_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_SEPARATOR)
            begin
                sep_reg <= wr_data;
            end
            if (wr_index == REG_QUOTE)
            begin
                quote_reg <= wr_data;
            end
        end
    end

    assign is_quote = (char_byte == quote_reg);
    assign is_sep   = (char_byte == sep_reg) && !inq_reg;

    always_comb
    begin
        inq_next            = inq_reg;
        acq_next            = acq_reg;
        cnt_next            = cnt_reg;
        emit                = 1'b1;
        q_data.out_byte     = char_byte;
        q_data.field_number = cnt_reg;
        q_data.field_end    = 1'b0;
        q_data.record_end   = 1'b0;
        priority if (line_end)
        begin
            q_data.out_byte   = 8'd0;
            q_data.field_end  = 1'b1;
            q_data.record_end = 1'b1;
            inq_next          = 1'b0;
            acq_next          = 1'b0;
            cnt_next          = 2'd0;
        end
        else if (is_quote)
        begin
            // doubled quote gives one literal quote
            emit     = acq_reg;
            acq_next = inq_reg;
            inq_next = !inq_reg;
        end
        else if (is_sep)
        begin
            acq_next         = 1'b0;
            q_data.out_byte  = 8'd0;
            q_data.field_end = 1'b1;
            if (cnt_reg != FIELD_SURPLUS)
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else
        begin
            acq_next = 1'b0;
        end
    end

    assign q_wr = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg <= 1'b0;
            acq_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            inq_reg <= inq_next;
            acq_reg <= acq_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/csvfs_queue.sv -----
// ----------------------------------------------------------------------------
// csvfs_queue
// Small register queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module csvfs_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  csvfs_pkg::res_t     wr_data,
    input  logic                rd,
    output csvfs_pkg::res_t     rd_data,
    output csvfs_pkg::q_stat_t  stat
);
    import csvfs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- src/csvfs_back.sv -----
// ----------------------------------------------------------------------------
// csvfs_back
// Output register: takes the oldest queued item and holds it until popped.
// ----------------------------------------------------------------------------
module csvfs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  csvfs_pkg::q_stat_t  q_stat,
    input  csvfs_pkg::res_t     q_data,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output csvfs_pkg::res_t     res
);
    import csvfs_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // refill when the register is free or being drained this cycle
    assign q_rd = !q_stat.empty && (!valid_reg || pop);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_rd)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            res_reg <= q_data;
        end
    end

    assign empty = !valid_reg;
    assign res   = res_reg;

endmodule

// ----- src/csv_field_splitter.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a text line into CSV fields, one character per item.
// ----------------------------------------------------------------------------
// Input side is a queue write port: an item (char_byte, line_end) is taken
// at a clock edge with push high and full low. Result side is a queue read
// port: the oldest result sits on out_byte/field_number/field_end/record_end
// while empty is low and is taken at an edge with pop high.
// A character gives zero or one result; a line end always gives a closing
// result with field_end and record_end set and then clears the quote and
// field state. The user must write separator and quote bytes through wr_en/
// wr_index/wr_data only while the block is idle; the block does not enforce it.
// Throughput is one item per cycle while full is low: the classifier state
// registers are fed back through combinational next-state logic. A result
// goes through the queue and then the output register, which loads it when
// it is free or being popped; from there it can be popped.
// If pop stays low the output register holds, the queue fills and full rises
// after QUEUE_DEPTH further results; items that give no result take no queue
// space, but nothing is taken while full is high.
// Reset empties the queue and output, clears the state and restores comma
// and double quote as separator and quote.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [csvfs_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         char_byte,
    input  logic                               line_end,
    output logic                               empty,
    input  logic                               pop,
    output logic [7:0]                         out_byte,
    output logic [1:0]                         field_number,
    output logic                               field_end,
    output logic                               record_end
);
    import csvfs_pkg::*;

    logic    accept;
    logic    q_wr;
    logic    q_rd;
    res_t    q_wdata;
    res_t    q_rdata;
    res_t    res;
    q_stat_t q_stat;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    csvfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .accept    (accept),
        .char_byte (char_byte),
        .line_end  (line_end),
        .q_wr      (q_wr),
        .q_data    (q_wdata)
    );

    csvfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .stat    (q_stat)
    );

    csvfs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (q_rdata),
        .q_rd   (q_rd),
        .pop    (pop),
        .empty  (empty),
        .res    (res)
    );

    assign out_byte     = res.out_byte;
    assign field_number = res.field_number;
    assign field_end    = res.field_end;
    assign record_end   = res.record_end;

endmodule

// ----- src/csvfs_checker.sv -----
// ----------------------------------------------------------------------------
// csvfs_checker
// Port-level checks on the csv field splitter result side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic [1:0] field_number,
    input logic       field_end,
    input logic       record_end
);

    // a closing item carries no byte
    `CHK_ASSERT_DEF(a_end_no_byte, (!empty && field_end) |-> (out_byte == 8'd0), "closing item with byte")

    // record end only on a closing item
    `CHK_ASSERT_DEF(a_rec_is_field_end, (!empty && record_end) |-> field_end, "record end without field end")

    // field number saturates at surplus
    `CHK_ASSERT_DEF(a_field_num_range, !empty |-> (field_number != 2'd3), "field number out of range")

    // an offered item stays until taken
    `CHK_ASSERT_DEF(a_hold_until_pop, (!empty && !pop) |=> (!empty && $stable(out_byte)), "item dropped while stalled")

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .field_number (field_number),
    .field_end    (field_end),
    .record_end   (record_end)
);

// ----- verif/csv_field_splitter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_field_splitter_tb
// Self-checking bench for the csv field splitter. Drives characters and line
// ends through the push/full port, predicts each result with a local copy of
// the quote and field state, and checks every popped result in order. Runs
// directed quoting cases, then random lines under several delimiter settings
// and handshake idling patterns.
// ----------------------------------------------------------------------------
module csv_field_splitter_tb;
    import csvfs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = REG_SEPARATOR;
    logic [CFG_DATA_W-1:0] wr_data  = '0;
    logic       push       = 1'b0;
    logic [7:0] char_byte  = '0;
    logic       line_end   = 1'b0;
    logic       pop        = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [1:0] field_number;
    logic       field_end;
    logic       record_end;

    // local copy of the delimiters and the splitter state
    logic [7:0] separator_cfg = SEPARATOR_RESET;
    logic [7:0] quote_cfg     = QUOTE_RESET;
    logic       in_quotes     = 1'b0;
    logic       after_quote   = 1'b0;
    logic [1:0] field_count   = '0;

    res_t pending_fields[$];
    res_t want;

    int send_gap_pct    = 0;
    int pop_stall_pct   = 0;
    int items_sent      = 0;
    int lines_sent      = 0;
    int results_checked = 0;
    int settings_used   = 1;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    csv_field_splitter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .push         (push),
        .full         (full),
        .char_byte    (char_byte),
        .line_end     (line_end),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .field_number (field_number),
        .field_end    (field_end),
        .record_end   (record_end)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // returns 1 when the item produces a result, updating the split state
    function automatic bit predict_field_output(input logic [7:0] c, input logic eol,
                                                output res_t r);
        bit emits;
        r = '0;
        r.field_number = field_count;
        if (eol)
        begin
            r.field_end  = 1'b1;
            r.record_end = 1'b1;
            in_quotes    = 1'b0;
            after_quote  = 1'b0;
            field_count  = '0;
            return 1'b1;
        end
        if (c == quote_cfg)
        begin
            // only the second quote of a doubled pair comes out as a literal
            r.out_byte  = c;
            emits       = after_quote;
            after_quote = in_quotes;
            in_quotes   = !in_quotes;
            return emits;
        end
        after_quote = 1'b0;
        if (c == separator_cfg && !in_quotes)
        begin
            r.field_end = 1'b1;
            if (field_count < FIELD_SURPLUS)
                field_count++;
            return 1'b1;
        end
        r.out_byte = c;
        return 1'b1;
    endfunction

    // result side: check each popped item, then pick next pop level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_fields.size() == 0)
                begin
                    $error("unexpected result: out_byte %0d field_number %0d field_end %0b",
                           out_byte, field_number, field_end);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_fields.pop_front();
                    results_checked++;
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0d, got %0d", want.out_byte, out_byte);
                        mismatch_count++;
                    end
                    if (field_number !== want.field_number)
                    begin
                        $error("field_number: expected %0d, got %0d",
                               want.field_number, field_number);
                        mismatch_count++;
                    end
                    if (field_end !== want.field_end)
                    begin
                        $error("field_end: expected %0b, got %0b", want.field_end, field_end);
                        mismatch_count++;
                    end
                    if (record_end !== want.record_end)
                    begin
                        $error("record_end: expected %0b, got %0b",
                               want.record_end, record_end);
                        mismatch_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // leaves push high on return; drain_results lowers it, the next call only for its random gaps
    task automatic send_item(input logic [7:0] c, input logic eol);
        res_t r;
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_byte <= c;
        line_end  <= eol;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        if (eol)
            lines_sent++;
        if (predict_field_output(c, eol, r))
            pending_fields.push_back(r);
    endtask

    // stop sending, wait for every result, then let items with no result settle
    task automatic drain_results();
        push <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_delimiters(input logic [7:0] sep, input logic [7:0] quo);
        drain_results();
        wr_en    <= 1'b1;
        wr_index <= REG_SEPARATOR;
        wr_data  <= sep;
        @(posedge clk);
        wr_index <= REG_QUOTE;
        wr_data  <= quo;
        @(posedge clk);
        wr_en <= 1'b0;
        separator_cfg = sep;
        quote_cfg     = quo;
        settings_used++;
        @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == separator_cfg || b == quote_cfg);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return quote_cfg;
        if (pick < 4)
            return separator_cfg;
        return 8'($urandom_range(255));
    endfunction

    // mostly well-formed lines with random content, some noise lines
    task automatic send_random_line();
        int n_fields;
        int len;
        bit quoted;
        if ($urandom_range(99) < 80)
        begin
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields; f++)
            begin
                if (f != 0)
                    send_item(separator_cfg, 1'b0);
                quoted = 1'($urandom_range(1));
                len    = $urandom_range(0, 6);
                if (quoted)
                    send_item(quote_cfg, 1'b0);
                for (int k = 0; k < len; k++)
                begin
                    if (quoted && $urandom_range(9) == 0)
                    begin
                        send_item(quote_cfg, 1'b0);
                        send_item(quote_cfg, 1'b0);
                    end
                    else if (quoted && $urandom_range(9) == 0)
                        send_item(separator_cfg, 1'b0);
                    else
                        send_item(plain_byte(), 1'b0);
                end
                if (quoted)
                    send_item(quote_cfg, 1'b0);
            end
        end
        else
        begin
            len = $urandom_range(0, 10);
            for (int k = 0; k < len; k++)
                send_item(noise_byte(), 1'b0);
        end
        // now and then a line runs on into the next one
        if ($urandom_range(19) != 0)
            send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // a,"b""c",,"x,y"z,<00><ff> then line end: doubled quote, separator in
    // quotes, empty field, surplus fields, extreme byte values
    task automatic test_quoting_rules();
        send_item("a", 1'b0);
        send_item(",", 1'b0);
        send_item("\"", 1'b0);
        send_item("b", 1'b0);
        send_item("\"", 1'b0);
        send_item("\"", 1'b0);
        send_item("c", 1'b0);
        send_item("\"", 1'b0);
        send_item(",", 1'b0);
        send_item(",", 1'b0);
        send_item("\"", 1'b0);
        send_item("x", 1'b0);
        send_item(",", 1'b0);
        send_item("y", 1'b0);
        send_item("\"", 1'b0);
        send_item("z", 1'b0);
        send_item(",", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // line end while quoted must clear the state for the next line
    task automatic test_line_end_in_quotes();
        send_item("\"", 1'b0);
        send_item("q", 1'b0);
        send_item(8'hff, 1'b1);
        send_item(",", 1'b0);
        send_item(8'h5a, 1'b1);
    endtask

    // separator equal to quote: quote meaning wins
    task automatic test_shared_delimiter();
        set_delimiters(8'd34, 8'd34);
        send_item("\"", 1'b0);
        send_item("a", 1'b0);
        send_item("\"", 1'b0);
        send_item("\"", 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_random_lines(input int gap_pct, input int stall_pct,
                                     input logic [7:0] sep, input logic [7:0] quo,
                                     input int n_items);
        int start;
        set_delimiters(sep, quo);
        send_gap_pct  = gap_pct;
        pop_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_line();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_quoting_rules();
        test_line_end_in_quotes();
        test_shared_delimiter();
        test_random_lines(0, 0, SEPARATOR_RESET, QUOTE_RESET, 270);
        test_random_lines(66, 0, 8'h00, 8'hff, 270);
        test_random_lines(0, 66, 8'hff, 8'h00, 270);
        test_random_lines(27, 27, 8'($urandom_range(255)), 8'($urandom_range(255)), 270);

        drain_results();
        $display("sent %0d items in %0d lines under %0d delimiter settings",
                 items_sent, lines_sent, settings_used);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/csvfs_pkg.sv
src/csvfs_front.sv
src/csvfs_queue.sv
src/csvfs_back.sv
src/csv_field_splitter.sv
src/csvfs_checker.sv
verif/csv_field_splitter_tb.sv
